@@ src/fra_pkg.sv @@
// Shared types, codes and decode helpers for the four-register ALU.
package fra_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ImmW = 16;
  localparam int unsigned NumRegs = 4;
  localparam int unsigned RegIdxW = $clog2(NumRegs);
  localparam int unsigned ModeW = 4;

  typedef logic [DataW-1:0] data_t;
  typedef logic [RegIdxW-1:0] reg_idx_t;

  // Instruction codes; codes past MODE_NOP behave as nop.
  typedef enum logic [ModeW-1:0] {
    MODE_LOAD  = 4'd0,
    MODE_ADD_R = 4'd1,
    MODE_MUL_R = 4'd2,
    MODE_DIV_R = 4'd3,
    MODE_MOD_R = 4'd4,
    MODE_EQL_R = 4'd5,
    MODE_ADD_I = 4'd6,
    MODE_MUL_I = 4'd7,
    MODE_DIV_I = 4'd8,
    MODE_MOD_I = 4'd9,
    MODE_EQL_I = 4'd10,
    MODE_NOP   = 4'd11
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_MOD,
    OP_EQL
  } alu_op_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic div_write;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
  } status_t;

  function automatic alu_op_e decode_op(input logic [ModeW-1:0] mode);
    alu_op_e op;
    unique case (mode)
      MODE_LOAD:              op = OP_LOAD;
      MODE_ADD_R, MODE_ADD_I: op = OP_ADD;
      MODE_MUL_R, MODE_MUL_I: op = OP_MUL;
      MODE_DIV_R, MODE_DIV_I: op = OP_DIV;
      MODE_MOD_R, MODE_MOD_I: op = OP_MOD;
      MODE_EQL_R, MODE_EQL_I: op = OP_EQL;
      default:                op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic uses_imm(input logic [ModeW-1:0] mode);
    return (mode >= MODE_ADD_I) && (mode <= MODE_EQL_I);
  endfunction

endpackage

@@ src/fra_in_if.sv @@
// Instruction channel: valid/ready plus one instruction per beat.
interface fra_in_if import fra_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ModeW-1:0]        mode;
  logic [RegIdxW-1:0]      dest_reg;
  logic [RegIdxW-1:0]      src_reg;
  logic signed [ImmW-1:0]  immediate;
  logic signed [DataW-1:0] load_value;
  logic                    clear_first;

  modport source (
    output valid, mode, dest_reg, src_reg, immediate, load_value, clear_first,
    input  ready
  );
  modport sink (
    input  valid, mode, dest_reg, src_reg, immediate, load_value, clear_first,
    output ready
  );
endinterface

@@ src/fra_out_if.sv @@
// Result channel: valid/ready plus the register file snapshot per beat.
interface fra_out_if import fra_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] reg_w;
  logic signed [DataW-1:0] reg_x;
  logic signed [DataW-1:0] reg_y;
  logic signed [DataW-1:0] reg_z;
  logic                    div_error;

  modport source (
    output valid, reg_w, reg_x, reg_y, reg_z, div_error,
    input  ready
  );
  modport sink (
    input  valid, reg_w, reg_x, reg_y, reg_z, div_error,
    output ready
  );
endinterface

@@ src/four_register_alu_execute.sv @@
// Top level of the four-register ALU: controller, datapath and channel ports.
//
//   port   dir  beat contents
//   in_i   in   mode, dest_reg, src_reg, immediate, load_value, clear_first
//   out_o  out  reg_w, reg_x, reg_y, reg_z, div_error
//
// One instruction at a time: accept, execute, then load the result register;
// divide and remainder by a nonzero operand also wait for the bit-serial
// divider. A zero divisor takes the short path.
// Reset zeroes the register file and drops out_o.valid.
// A stalled result beat holds; the next instruction is still taken and waits
// in write-back until the result register frees.
module four_register_alu_execute import fra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  fra_in_if.sink    in_i,
  fra_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  fra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fra_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (in_i.mode),
    .dest_reg_i    (in_i.dest_reg),
    .src_reg_i     (in_i.src_reg),
    .immediate_i   (in_i.immediate),
    .load_value_i  (in_i.load_value),
    .clear_first_i (in_i.clear_first),
    .reg_w_o       (out_o.reg_w),
    .reg_x_o       (out_o.reg_x),
    .reg_y_o       (out_o.reg_y),
    .reg_z_o       (out_o.reg_z),
    .div_error_o   (out_o.div_error)
  );

endmodule

@@ src/fra_div.sv @@
// Iterative unsigned restoring divider, one quotient bit per cycle.
module fra_div import fra_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  data_t dividend_i,
  input  data_t divisor_i,
  output logic  done_o,
  output data_t quotient_o,
  output data_t remainder_o
);

  localparam int unsigned CntW = $clog2(DataW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  data_t           quo_q, quo_d;
  data_t           rem_q, rem_d;
  data_t           dsr_q, dsr_d;
  logic [DataW:0]  trial;

  // Partial remainder stays below the divisor, so the shifted value fits DataW+1 bits.
  assign trial = {rem_q, quo_q[DataW-1]} - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!trial[DataW]) begin
        rem_d = trial[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DataW-2:0], quo_q[DataW-1]};
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == '0)
    else $error("divider not busy after start");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("divider done without a finished run");

endmodule

@@ src/fra_dp.sv @@
// Datapath: instruction latch, register file, ALU, divider and result register.
module fra_dp import fra_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic [ModeW-1:0]        mode_i,
  input  reg_idx_t                dest_reg_i,
  input  reg_idx_t                src_reg_i,
  input  logic signed [ImmW-1:0]  immediate_i,
  input  logic signed [DataW-1:0] load_value_i,
  input  logic                    clear_first_i,
  output logic signed [DataW-1:0] reg_w_o,
  output logic signed [DataW-1:0] reg_x_o,
  output logic signed [DataW-1:0] reg_y_o,
  output logic signed [DataW-1:0] reg_z_o,
  output logic                    div_error_o
);

  logic [ModeW-1:0] mode_q;
  reg_idx_t         dest_q;
  reg_idx_t         src_q;
  logic [ImmW-1:0]  imm_q;
  data_t            load_q;

  data_t            rf_q [NumRegs];
  logic             err_q;
  logic             quo_neg_q, rem_neg_q, want_rem_q;

  data_t            out_q [NumRegs];
  logic             out_err_q;

  alu_op_e          op;
  data_t            opa, opb, alu_res;
  logic             is_divmod, b_zero, alu_write;
  data_t            mag_a, mag_b;
  logic             div_done;
  data_t            quo, rem, div_res;

  assign op        = decode_op(mode_q);
  assign opa       = rf_q[dest_q];
  assign opb       = uses_imm(mode_q) ? data_t'({{(DataW-ImmW){imm_q[ImmW-1]}}, imm_q})
                                      : rf_q[src_q];
  assign is_divmod = (op == OP_DIV) || (op == OP_MOD);
  assign b_zero    = (opb == '0);
  assign mag_a     = opa[DataW-1] ? (~opa + 1'b1) : opa;
  assign mag_b     = opb[DataW-1] ? (~opb + 1'b1) : opb;

  always_comb begin
    alu_res   = '0;
    alu_write = 1'b1;
    unique case (op)
      OP_LOAD: alu_res = load_q;
      OP_ADD:  alu_res = opa + opb;
      OP_MUL:  alu_res = opa * opb;  // low word only
      OP_EQL:  alu_res = data_t'(opa == opb);
      default: alu_write = 1'b0;     // nop; div/mod write back later
    endcase
  end

  fra_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (mag_a),
    .divisor_i   (mag_b),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_comb begin
    if (want_rem_q) div_res = rem_neg_q ? (~rem + 1'b1) : rem;
    else            div_res = quo_neg_q ? (~quo + 1'b1) : quo;
  end

  assign status_o.div_needed = is_divmod && !b_zero;
  assign status_o.div_done   = div_done;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      dest_q <= dest_reg_i;
      src_q  <= src_reg_i;
      imm_q  <= immediate_i;
      load_q <= load_value_i;
    end
    if (cmd_i.exec) err_q <= is_divmod && b_zero;
    if (cmd_i.div_start) begin
      quo_neg_q  <= opa[DataW-1] ^ opb[DataW-1];
      rem_neg_q  <= opa[DataW-1];
      want_rem_q <= (op == OP_MOD);
    end
    if (cmd_i.out_load) begin
      out_q     <= rf_q;
      out_err_q <= err_q;
    end
  end

  // Register file: clear on capture when clear_first is set, single write port afterwards.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
    end else begin
      priority if (cmd_i.capture && clear_first_i) begin
        for (int i = 0; i < NumRegs; i++) rf_q[i] <= '0;
      end else if (cmd_i.exec && alu_write) begin
        rf_q[dest_q] <= alu_res;
      end else if (cmd_i.div_write) begin
        rf_q[dest_q] <= div_res;
      end else begin
        rf_q <= rf_q;
      end
    end
  end

  assign reg_w_o     = out_q[0];
  assign reg_x_o     = out_q[1];
  assign reg_y_o     = out_q[2];
  assign reg_z_o     = out_q[3];
  assign div_error_o = out_err_q;

endmodule

@@ src/fra_ctrl.sv @@
// Controller: sequences capture, execute, divide wait and result hand-off.
module fra_ctrl import fra_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WB
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.capture   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.exec      = (state_q == ST_EXEC);
    cmd_o.div_start = (state_q == ST_EXEC) && status_i.div_needed;
    cmd_o.div_write = (state_q == ST_DIV) && status_i.div_done;
    // result slot frees up the same cycle the sink takes the old beat
    cmd_o.out_load  = (state_q == ST_WB) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: state_d = status_i.div_needed ? ST_DIV : ST_WB;
      ST_DIV:  if (status_i.div_done) state_d = ST_WB;
      ST_WB:   if (cmd_o.out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_start_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == ST_DIV)
    else $error("divide started but controller not waiting");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == ST_DIV)
    else $error("divider finished outside divide wait");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q && state_q == ST_IDLE)
    else $error("result load did not raise valid");

endmodule
